// ===== sv/amex_pkg.sv =====
// amex_pkg: shared types and constants for the execute stage
// condition codes, alu opcodes, flag bit positions, stage and result structs
// no dependencies
`default_nettype none

package amex_pkg;

	localparam int WordW    = 32;
	localparam int RegCount = 16;
	localparam int RegIdxW  = $clog2(RegCount);
	localparam int FlagW    = 4;

	localparam int FLAG_N = 3;
	localparam int FLAG_Z = 2;
	localparam int FLAG_C = 1;
	localparam int FLAG_V = 0;

	localparam logic KIND_DP  = 1'b0;
	localparam logic KIND_MUL = 1'b1;

	localparam logic [3:0] COND_EQ = 4'd0;
	localparam logic [3:0] COND_NE = 4'd1;
	localparam logic [3:0] COND_CS = 4'd2;
	localparam logic [3:0] COND_CC = 4'd3;
	localparam logic [3:0] COND_MI = 4'd4;
	localparam logic [3:0] COND_PL = 4'd5;
	localparam logic [3:0] COND_VS = 4'd6;
	localparam logic [3:0] COND_VC = 4'd7;
	localparam logic [3:0] COND_HI = 4'd8;
	localparam logic [3:0] COND_LS = 4'd9;
	localparam logic [3:0] COND_GE = 4'd10;
	localparam logic [3:0] COND_LT = 4'd11;
	localparam logic [3:0] COND_GT = 4'd12;
	localparam logic [3:0] COND_LE = 4'd13;
	localparam logic [3:0] COND_AL = 4'd14;

	localparam logic [3:0] ALU_AND = 4'd0;
	localparam logic [3:0] ALU_EOR = 4'd1;
	localparam logic [3:0] ALU_SUB = 4'd2;
	localparam logic [3:0] ALU_RSB = 4'd3;
	localparam logic [3:0] ALU_ADD = 4'd4;
	localparam logic [3:0] ALU_TST = 4'd8;
	localparam logic [3:0] ALU_TEQ = 4'd9;
	localparam logic [3:0] ALU_CMP = 4'd10;
	localparam logic [3:0] ALU_ORR = 4'd12;
	localparam logic [3:0] ALU_MOV = 4'd13;

	typedef struct packed {
		logic               kind;
		logic [3:0]         condition;
		logic [3:0]         alu_op;
		logic               update_flags;
		logic [RegIdxW-1:0] target_index;
		logic [WordW-1:0]   second_value;
		logic               shift_carry;
		logic               accumulate_on;
	} stage_t;

	typedef struct packed {
		logic               passed;
		logic               wrote;
		logic [RegIdxW-1:0] written_index;
		logic [WordW-1:0]   written_value;
		logic [FlagW-1:0]   flag_bits;
	} result_t;

	typedef struct packed {
		logic               en;
		logic [RegIdxW-1:0] index;
		logic [WordW-1:0]   value;
	} wr_t;

endpackage

`default_nettype wire

// ===== sv/amex_regfile.sv =====
// amex_regfile: 16 x 32 register file, two copies for three read ports
// registered reads with bypass of the write in the same cycle; per-entry valid bits
// depends on amex_pkg
`default_nettype none

module amex_regfile (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire amex_pkg::wr_t                 wr,
	input  wire logic                          rd_en,
	input  wire logic [amex_pkg::RegIdxW-1:0]  rd_addr0,
	input  wire logic [amex_pkg::RegIdxW-1:0]  rd_addr1,
	input  wire logic [amex_pkg::RegIdxW-1:0]  rd_addr2,
	output logic      [amex_pkg::WordW-1:0]    rd_data0,
	output logic      [amex_pkg::WordW-1:0]    rd_data1,
	output logic      [amex_pkg::WordW-1:0]    rd_data2
);

	logic [amex_pkg::WordW-1:0]    mem0_q [amex_pkg::RegCount];
	logic [amex_pkg::WordW-1:0]    mem1_q [amex_pkg::RegCount];
	logic [amex_pkg::RegCount-1:0] valid_q;

	logic [amex_pkg::WordW-1:0] raw0_q, raw1_q, raw2_q;
	logic [amex_pkg::WordW-1:0] byp_data_q;
	logic [2:0]                 byp_q;
	logic [2:0]                 vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem0_q[wr.index] <= wr.value;
			mem1_q[wr.index] <= wr.value;
		end
		if (rd_en) begin
			raw0_q     <= mem0_q[rd_addr0];
			raw1_q     <= mem0_q[rd_addr1];
			raw2_q     <= mem1_q[rd_addr2];
			byp_data_q <= wr.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			byp_q   <= '0;
			vld_q   <= '0;
		end else begin
			if (wr.en) begin
				valid_q[wr.index] <= 1'b1;
			end
			if (rd_en) begin
				byp_q[0] <= wr.en && (wr.index == rd_addr0);
				byp_q[1] <= wr.en && (wr.index == rd_addr1);
				byp_q[2] <= wr.en && (wr.index == rd_addr2);
				vld_q[0] <= valid_q[rd_addr0];
				vld_q[1] <= valid_q[rd_addr1];
				vld_q[2] <= valid_q[rd_addr2];
			end
		end
	end

	// entries never written read as zero
	assign rd_data0 = byp_q[0] ? byp_data_q : (vld_q[0] ? raw0_q : '0);
	assign rd_data1 = byp_q[1] ? byp_data_q : (vld_q[1] ? raw1_q : '0);
	assign rd_data2 = byp_q[2] ? byp_data_q : (vld_q[2] ? raw2_q : '0);

endmodule

`default_nettype wire

// ===== sv/amex_alu.sv =====
// amex_alu: condition test, data-processing alu, multiply-accumulate, flag update
// purely combinational; depends on amex_pkg
`default_nettype none

module amex_alu (
	input  wire amex_pkg::stage_t               stage,
	input  wire logic [amex_pkg::WordW-1:0]     op_a,
	input  wire logic [amex_pkg::WordW-1:0]     op_m,
	input  wire logic [amex_pkg::WordW-1:0]     op_addend,
	input  wire logic [amex_pkg::FlagW-1:0]     flags,
	output amex_pkg::result_t                   res
);

	logic [amex_pkg::WordW:0]   sum;
	logic [amex_pkg::WordW:0]   diff_ab;
	logic [amex_pkg::WordW:0]   diff_ba;
	logic [amex_pkg::WordW-1:0] prod;
	logic [amex_pkg::WordW-1:0] mac;
	logic [amex_pkg::WordW-1:0] val;
	logic                       cond_ok;
	logic                       carry;
	logic                       known;
	logic                       writes;
	logic                       fn, fz, fc, fv;

	assign fn = flags[amex_pkg::FLAG_N];
	assign fz = flags[amex_pkg::FLAG_Z];
	assign fc = flags[amex_pkg::FLAG_C];
	assign fv = flags[amex_pkg::FLAG_V];

	assign sum     = {1'b0, op_a} + {1'b0, stage.second_value};
	assign diff_ab = {1'b0, op_a} - {1'b0, stage.second_value};
	assign diff_ba = {1'b0, stage.second_value} - {1'b0, op_a};
	assign prod    = op_a * op_m;
	assign mac     = prod + (stage.accumulate_on ? op_addend : '0);

	always_comb begin
		case (stage.condition)
			amex_pkg::COND_EQ: cond_ok = fz;
			amex_pkg::COND_NE: cond_ok = !fz;
			amex_pkg::COND_CS: cond_ok = fc;
			amex_pkg::COND_CC: cond_ok = !fc;
			amex_pkg::COND_MI: cond_ok = fn;
			amex_pkg::COND_PL: cond_ok = !fn;
			amex_pkg::COND_VS: cond_ok = fv;
			amex_pkg::COND_VC: cond_ok = !fv;
			amex_pkg::COND_HI: cond_ok = fc && !fz;
			amex_pkg::COND_LS: cond_ok = !fc || fz;
			amex_pkg::COND_GE: cond_ok = (fn == fv);
			amex_pkg::COND_LT: cond_ok = (fn != fv);
			amex_pkg::COND_GT: cond_ok = !fz && (fn == fv);
			amex_pkg::COND_LE: cond_ok = fz || (fn != fv);
			amex_pkg::COND_AL: cond_ok = 1'b1;
			default:           cond_ok = 1'b0;
		endcase
	end

	always_comb begin
		val    = '0;
		carry  = stage.shift_carry;
		known  = 1'b1;
		writes = 1'b1;
		case (stage.alu_op)
			amex_pkg::ALU_AND: val = op_a & stage.second_value;
			amex_pkg::ALU_EOR: val = op_a ^ stage.second_value;
			amex_pkg::ALU_SUB: begin
				val   = diff_ab[amex_pkg::WordW-1:0];
				carry = !diff_ab[amex_pkg::WordW];
			end
			amex_pkg::ALU_RSB: begin
				val   = diff_ba[amex_pkg::WordW-1:0];
				carry = !diff_ba[amex_pkg::WordW];
			end
			amex_pkg::ALU_ADD: begin
				val   = sum[amex_pkg::WordW-1:0];
				carry = sum[amex_pkg::WordW];
			end
			amex_pkg::ALU_TST: begin
				val    = op_a & stage.second_value;
				writes = 1'b0;
			end
			amex_pkg::ALU_TEQ: begin
				val    = op_a ^ stage.second_value;
				writes = 1'b0;
			end
			amex_pkg::ALU_CMP: begin
				val    = diff_ab[amex_pkg::WordW-1:0];
				carry  = !diff_ab[amex_pkg::WordW];
				writes = 1'b0;
			end
			amex_pkg::ALU_ORR: val = op_a | stage.second_value;
			amex_pkg::ALU_MOV: val = stage.second_value;
			default: begin
				known  = 1'b0;
				writes = 1'b0;
			end
		endcase
	end

	always_comb begin
		res               = '0;
		res.flag_bits     = flags;
		if (cond_ok) begin
			res.passed = 1'b1;
			if (stage.kind == amex_pkg::KIND_MUL) begin
				res.wrote         = 1'b1;
				res.written_value = mac;
				if (stage.update_flags) begin
					res.flag_bits[amex_pkg::FLAG_N] = mac[amex_pkg::WordW-1];
					res.flag_bits[amex_pkg::FLAG_Z] = (mac == '0);
				end
			end else if (known) begin
				res.wrote         = writes;
				res.written_value = val;
				if (stage.update_flags) begin
					res.flag_bits[amex_pkg::FLAG_N] = val[amex_pkg::WordW-1];
					res.flag_bits[amex_pkg::FLAG_Z] = (val == '0);
					res.flag_bits[amex_pkg::FLAG_C] = carry;
				end
			end
			if (res.wrote) begin
				res.written_index = stage.target_index;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/arm_alu_multiply_execute.sv =====
// arm_alu_multiply_execute: execute stage for decoded data-processing and multiply words
// input register, register file with bypass, alu and result register
// depends on amex_pkg, amex_regfile, amex_alu
//
// channels: input word on in_valid/in_ready, result word on out_valid/out_ready,
// both accepted when valid and ready are high at a rising edge of clk
// each input word gives exactly one result word, in order
// path: an accepted word waits in the input register until the result register is free,
// then its result is registered in the result register together with out_valid
// throughput: one word per cycle while results are taken; operands are read from
// the register file as a word is accepted, and the destination and the flags are
// written as the result is registered, so the next word always sees the updated state
// stall: when out_ready is low the result holds, one more word waits in the input
// register, and in_ready drops until the result is taken
// reset: arst_n clears the register file (by valid bits), the NZCV flags and both
// valid flags; the block is ready for a word right after reset
`default_nettype none

module arm_alu_multiply_execute (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [3:0]  condition,
	input  wire logic [3:0]  alu_op,
	input  wire logic        update_flags,
	input  wire logic [3:0]  target_index,
	input  wire logic [3:0]  first_index,
	input  wire logic [31:0] second_value,
	input  wire logic        shift_carry,
	input  wire logic [3:0]  mul_index,
	input  wire logic        accumulate_on,
	input  wire logic [3:0]  addend_index,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             passed,
	output logic             wrote,
	output logic [3:0]       written_index,
	output logic [31:0]      written_value,
	output logic [3:0]       flag_bits
);

	amex_pkg::stage_t  stage_s1;
	logic              valid_s1;
	amex_pkg::result_t res;
	amex_pkg::result_t res_q;
	logic              out_valid_q;
	logic [amex_pkg::FlagW-1:0] flags_q;
	amex_pkg::wr_t     wr;
	logic              in_accept;
	logic              advance;
	logic [amex_pkg::WordW-1:0] op_a, op_m, op_addend;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign in_accept = in_valid && in_ready;

	assign wr.en    = advance && res.wrote;
	assign wr.index = res.written_index;
	assign wr.value = res.written_value;

	amex_regfile u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.rd_en    (in_accept),
		.rd_addr0 (first_index),
		.rd_addr1 (mul_index),
		.rd_addr2 (addend_index),
		.rd_data0 (op_a),
		.rd_data1 (op_m),
		.rd_data2 (op_addend)
	);

	amex_alu u_alu (
		.stage     (stage_s1),
		.op_a      (op_a),
		.op_m      (op_m),
		.op_addend (op_addend),
		.flags     (flags_q),
		.res       (res)
	);

	always_ff @(posedge clk) begin
		if (in_accept) begin
			stage_s1.kind          <= kind;
			stage_s1.condition     <= condition;
			stage_s1.alu_op        <= alu_op;
			stage_s1.update_flags  <= update_flags;
			stage_s1.target_index  <= target_index;
			stage_s1.second_value  <= second_value;
			stage_s1.shift_carry   <= shift_carry;
			stage_s1.accumulate_on <= accumulate_on;
		end
		if (advance) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			flags_q     <= '0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				flags_q     <= res.flag_bits;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign passed        = res_q.passed;
	assign wrote         = res_q.wrote;
	assign written_index = res_q.written_index;
	assign written_value = res_q.written_value;
	assign flag_bits     = res_q.flag_bits;

	// overflow flag is never touched
	a_v_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		flags_q[amex_pkg::FLAG_V] == 1'b0)
		else $error("overflow flag changed");

	// a held result always reports the live flags
	a_flags_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.flag_bits == flags_q))
		else $error("result flags differ from flag register");

	// a failed condition leaves the flags alone
	a_fail_keeps_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !res.passed) |=> (flags_q == $past(flags_q)))
		else $error("flags changed on failed condition");

	// no write without a pass
	a_write_needs_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_q.passed) |-> (!res_q.wrote && (res_q.written_value == '0)))
		else $error("write reported on failed condition");

endmodule

`default_nettype wire

// ===== verif/arm_alu_multiply_execute_checker.sv =====
// arm_alu_multiply_execute_checker: watches both channels of the execute stage,
// keeps its own register file and flags, predicts each result word and compares
// depends on amex_pkg
`timescale 1ns / 100ps

module arm_alu_multiply_execute_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic        kind,
	input  wire logic [3:0]  condition,
	input  wire logic [3:0]  alu_op,
	input  wire logic        update_flags,
	input  wire logic [3:0]  target_index,
	input  wire logic [3:0]  first_index,
	input  wire logic [31:0] second_value,
	input  wire logic        shift_carry,
	input  wire logic [3:0]  mul_index,
	input  wire logic        accumulate_on,
	input  wire logic [3:0]  addend_index,

	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic        passed,
	input  wire logic        wrote,
	input  wire logic [3:0]  written_index,
	input  wire logic [31:0] written_value,
	input  wire logic [3:0]  flag_bits,

	output int               errors,
	output int               pending
);

	logic [amex_pkg::WordW-1:0] arch_regs [amex_pkg::RegCount];
	logic [amex_pkg::FlagW-1:0] arch_flags;
	amex_pkg::result_t          expected_results [$];

	function automatic logic condition_met(input logic [3:0] cond,
		input logic [amex_pkg::FlagW-1:0] f);
		logic n, z, c, v;
		n = f[amex_pkg::FLAG_N];
		z = f[amex_pkg::FLAG_Z];
		c = f[amex_pkg::FLAG_C];
		v = f[amex_pkg::FLAG_V];
		case (cond)
			amex_pkg::COND_EQ: return z;
			amex_pkg::COND_NE: return !z;
			amex_pkg::COND_CS: return c;
			amex_pkg::COND_CC: return !c;
			amex_pkg::COND_MI: return n;
			amex_pkg::COND_PL: return !n;
			amex_pkg::COND_VS: return v;
			amex_pkg::COND_VC: return !v;
			amex_pkg::COND_HI: return c && !z;
			amex_pkg::COND_LS: return !c || z;
			amex_pkg::COND_GE: return n == v;
			amex_pkg::COND_LT: return n != v;
			amex_pkg::COND_GT: return !z && (n == v);
			amex_pkg::COND_LE: return z || (n != v);
			amex_pkg::COND_AL: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// operands come from the state before this word writes anything
	task automatic execute_word(output amex_pkg::result_t r);
		logic [amex_pkg::WordW-1:0] a, b, m, addend, val;
		logic                       carry, writes, known;
		a      = arch_regs[first_index];
		b      = second_value;
		m      = arch_regs[mul_index];
		addend = arch_regs[addend_index];
		val    = '0;
		carry  = shift_carry;
		writes = 1'b1;
		known  = 1'b1;
		r      = '0;
		if (condition_met(condition, arch_flags)) begin
			r.passed = 1'b1;
			if (kind == amex_pkg::KIND_MUL) begin
				val = a * m;
				if (accumulate_on)
					val = val + addend;
				carry = arch_flags[amex_pkg::FLAG_C];
			end else begin
				case (alu_op)
					amex_pkg::ALU_AND: val = a & b;
					amex_pkg::ALU_EOR: val = a ^ b;
					amex_pkg::ALU_SUB: begin
						val   = a - b;
						carry = a >= b;
					end
					amex_pkg::ALU_RSB: begin
						val   = b - a;
						carry = b >= a;
					end
					amex_pkg::ALU_ADD: {carry, val} = {1'b0, a} + {1'b0, b};
					amex_pkg::ALU_TST: begin
						val    = a & b;
						writes = 1'b0;
					end
					amex_pkg::ALU_TEQ: begin
						val    = a ^ b;
						writes = 1'b0;
					end
					amex_pkg::ALU_CMP: begin
						val    = a - b;
						carry  = a >= b;
						writes = 1'b0;
					end
					amex_pkg::ALU_ORR: val = a | b;
					amex_pkg::ALU_MOV: val = b;
					default: begin
						known  = 1'b0;
						writes = 1'b0;
					end
				endcase
			end
			if (known && update_flags) begin
				arch_flags[amex_pkg::FLAG_N] = val[amex_pkg::WordW-1];
				arch_flags[amex_pkg::FLAG_Z] = val == '0;
				arch_flags[amex_pkg::FLAG_C] = carry;
			end
			r.written_value = val;
			if (writes) begin
				arch_regs[target_index] = val;
				r.wrote                 = 1'b1;
				r.written_index         = target_index;
			end
		end
		r.flag_bits = arch_flags;
	endtask

	always @(posedge clk or negedge arst_n) begin
		amex_pkg::result_t want, got;
		if (!arst_n) begin
			for (int i = 0; i < amex_pkg::RegCount; i++)
				arch_regs[i] = '0;
			arch_flags = '0;
			expected_results.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {passed, wrote, written_index, written_value, flag_bits};
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("%0t: result word with none expected", $realtime);
						$display("  actual   passed %0b wrote %0b idx %0d value %h flags %b",
							got.passed, got.wrote, got.written_index,
							got.written_value, got.flag_bits);
					end
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: result word mismatch", $realtime);
							$display("  expected passed %0b wrote %0b idx %0d value %h flags %b",
								want.passed, want.wrote, want.written_index,
								want.written_value, want.flag_bits);
							$display("  actual   passed %0b wrote %0b idx %0d value %h flags %b",
								got.passed, got.wrote, got.written_index,
								got.written_value, got.flag_bits);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				execute_word(want);
				expected_results.push_back(want);
			end
			pending = expected_results.size();
		end
	end

endmodule

// ===== verif/arm_alu_multiply_execute_tb.sv =====
// arm_alu_multiply_execute_tb: directed and random instruction words into the execute
// stage with random idling on both sides and one long output hold-off
// depends on amex_pkg, arm_alu_multiply_execute, arm_alu_multiply_execute_checker
`timescale 1ns / 100ps

module arm_alu_multiply_execute_tb;

	localparam logic [3:0] COND_NV     = 4'd15;
	localparam int         RandomWords = 1075;
	localparam int         HoldCycles  = 300;
	localparam int         HoldAfter   = 400;
	localparam int         DrainCycles = 20;
	localparam int         CycleLimit  = 600000;

	typedef struct packed {
		logic        kind;
		logic [3:0]  condition;
		logic [3:0]  alu_op;
		logic        update_flags;
		logic [3:0]  target_index;
		logic [3:0]  first_index;
		logic [31:0] second_value;
		logic        shift_carry;
		logic [3:0]  mul_index;
		logic        accumulate_on;
		logic [3:0]  addend_index;
	} instr_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        kind          = 1'b0;
	logic [3:0]  condition     = '0;
	logic [3:0]  alu_op        = '0;
	logic        update_flags  = 1'b0;
	logic [3:0]  target_index  = '0;
	logic [3:0]  first_index   = '0;
	logic [31:0] second_value  = '0;
	logic        shift_carry   = 1'b0;
	logic [3:0]  mul_index     = '0;
	logic        accumulate_on = 1'b0;
	logic [3:0]  addend_index  = '0;
	logic        out_ready     = 1'b0;

	wire logic        in_ready;
	wire logic        out_valid;
	wire logic        passed;
	wire logic        wrote;
	wire logic [3:0]  written_index;
	wire logic [31:0] written_value;
	wire logic [3:0]  flag_bits;

	int errors;
	int pending;
	int sent_words  = 0;
	int cycle_count = 0;
	bit no_gaps     = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	arm_alu_multiply_execute i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.condition     (condition),
		.alu_op        (alu_op),
		.update_flags  (update_flags),
		.target_index  (target_index),
		.first_index   (first_index),
		.second_value  (second_value),
		.shift_carry   (shift_carry),
		.mul_index     (mul_index),
		.accumulate_on (accumulate_on),
		.addend_index  (addend_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.passed        (passed),
		.wrote         (wrote),
		.written_index (written_index),
		.written_value (written_value),
		.flag_bits     (flag_bits)
	);

	arm_alu_multiply_execute_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.condition     (condition),
		.alu_op        (alu_op),
		.update_flags  (update_flags),
		.target_index  (target_index),
		.first_index   (first_index),
		.second_value  (second_value),
		.shift_carry   (shift_carry),
		.mul_index     (mul_index),
		.accumulate_on (accumulate_on),
		.addend_index  (addend_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.passed        (passed),
		.wrote         (wrote),
		.written_index (written_index),
		.written_value (written_value),
		.flag_bits     (flag_bits),
		.errors        (errors),
		.pending       (pending)
	);

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic logic is_known_op(input logic [3:0] op);
		case (op)
			amex_pkg::ALU_AND, amex_pkg::ALU_EOR, amex_pkg::ALU_SUB,
			amex_pkg::ALU_RSB, amex_pkg::ALU_ADD, amex_pkg::ALU_TST,
			amex_pkg::ALU_TEQ, amex_pkg::ALU_CMP, amex_pkg::ALU_ORR,
			amex_pkg::ALU_MOV: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [3:0] reserved_op();
		logic [3:0] op;
		do
			op = 4'($urandom_range(0, 15));
		while (is_known_op(op));
		return op;
	endfunction

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return 32'h0000_0001;
			5: return 32'($urandom_range(0, 255));
			default: return $urandom();
		endcase
	endfunction

	function automatic instr_t dp_word(input logic [3:0] cond, input logic [3:0] op,
		input logic upd, input logic [3:0] dst, input logic [3:0] src,
		input logic [31:0] val, input logic sc);
		instr_t w;
		w              = '0;
		w.kind         = amex_pkg::KIND_DP;
		w.condition    = cond;
		w.alu_op       = op;
		w.update_flags = upd;
		w.target_index = dst;
		w.first_index  = src;
		w.second_value = val;
		w.shift_carry  = sc;
		return w;
	endfunction

	function automatic instr_t mul_word(input logic [3:0] cond, input logic upd,
		input logic [3:0] dst, input logic [3:0] src_a, input logic [3:0] src_b,
		input logic acc, input logic [3:0] src_add);
		instr_t w;
		w               = '0;
		w.kind          = amex_pkg::KIND_MUL;
		w.condition     = cond;
		w.update_flags  = upd;
		w.target_index  = dst;
		w.first_index   = src_a;
		w.mul_index     = src_b;
		w.accumulate_on = acc;
		w.addend_index  = src_add;
		return w;
	endfunction

	function automatic instr_t random_word();
		instr_t w;
		w.kind      = ($urandom_range(0, 4) == 0) ? amex_pkg::KIND_MUL : amex_pkg::KIND_DP;
		w.condition = ($urandom_range(0, 1) == 0) ? amex_pkg::COND_AL
			: 4'($urandom_range(0, 15));
		if ($urandom_range(0, 15) == 0)
			w.alu_op = reserved_op();
		else begin
			case ($urandom_range(0, 9))
				0: w.alu_op = amex_pkg::ALU_AND;
				1: w.alu_op = amex_pkg::ALU_EOR;
				2: w.alu_op = amex_pkg::ALU_SUB;
				3: w.alu_op = amex_pkg::ALU_RSB;
				4: w.alu_op = amex_pkg::ALU_ADD;
				5: w.alu_op = amex_pkg::ALU_TST;
				6: w.alu_op = amex_pkg::ALU_TEQ;
				7: w.alu_op = amex_pkg::ALU_CMP;
				8: w.alu_op = amex_pkg::ALU_ORR;
				default: w.alu_op = amex_pkg::ALU_MOV;
			endcase
		end
		w.update_flags  = 1'($urandom_range(0, 1));
		w.target_index  = 4'($urandom_range(0, 15));
		w.first_index   = 4'($urandom_range(0, 15));
		w.second_value  = pick_operand();
		w.shift_carry   = 1'($urandom_range(0, 1));
		w.mul_index     = 4'($urandom_range(0, 15));
		w.accumulate_on = 1'($urandom_range(0, 1));
		w.addend_index  = 4'($urandom_range(0, 15));
		return w;
	endfunction

	// returns at the edge where the word is taken
	task automatic offer_word(input instr_t w);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		kind          <= w.kind;
		condition     <= w.condition;
		alu_op        <= w.alu_op;
		update_flags  <= w.update_flags;
		target_index  <= w.target_index;
		first_index   <= w.first_index;
		second_value  <= w.second_value;
		shift_carry   <= w.shift_carry;
		mul_index     <= w.mul_index;
		accumulate_on <= w.accumulate_on;
		addend_index  <= w.addend_index;
		in_valid      <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_words++;
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("arm_alu_multiply_execute_tb: done, errors");
			$finish;
		end
	end

	initial begin
		int high_len;
		int gap;
		bit held;
		held = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && sent_words >= HoldAfter) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
			end
			high_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 8);
			out_ready <= 1'b1;
			repeat (high_len) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// load extremes, then every op with its carry corner
		offer_word(dp_word(amex_pkg::COND_AL, amex_pkg::ALU_MOV, 1'b1, 4'd1, 4'd0,
			32'hFFFF_FFFF, 1'b1));
		offer_word(dp_word(amex_pkg::COND_AL, amex_pkg::ALU_MOV, 1'b0, 4'd2, 4'd0,
			32'h8000_0000, 1'b0));
		offer_word(dp_word(amex_pkg::COND_AL, amex_pkg::ALU_MOV, 1'b0, 4'd3, 4'd0,
			32'h0000_0001, 1'b0));
		offer_word(dp_word(amex_pkg::COND_AL, amex_pkg::ALU_MOV, 1'b0, 4'd15, 4'd0,
			32'h7FFF_FFFF, 1'b0));
		offer_word(dp_word(amex_pkg::COND_AL, amex_pkg::ALU_ADD, 1'b1, 4'd4, 4'd1,
			32'h0000_0001, 1'b0));
		offer_word(dp_word(amex_pkg::COND_AL, amex_pkg::ALU_ADD, 1'b1, 4'd5, 4'd15,
			32'h0000_0001, 1'b1));
		offer_word(dp_word(amex_pkg::COND_AL, amex_pkg::ALU_SUB, 1'b1, 4'd6, 4'd3,
			32'h0000_0001, 1'b0));
		offer_word(dp_word(amex_pkg::COND_AL, amex_pkg::ALU_SUB, 1'b1, 4'd7, 4'd0,
			32'h0000_0001, 1'b1));
		offer_word(dp_word(amex_pkg::COND_AL, amex_pkg::ALU_RSB, 1'b1, 4'd8, 4'd1,
			32'hFFFF_FFFF, 1'b0));
		offer_word(dp_word(amex_pkg::COND_AL, amex_pkg::ALU_RSB, 1'b1, 4'd9, 4'd3,
			32'h0000_0000, 1'b1));
		offer_word(dp_word(amex_pkg::COND_AL, amex_pkg::ALU_CMP, 1'b1, 4'd10, 4'd2,
			32'h8000_0000, 1'b0));
		offer_word(dp_word(amex_pkg::COND_AL, amex_pkg::ALU_TST, 1'b1, 4'd11, 4'd1,
			32'h0000_0000, 1'b0));
		offer_word(dp_word(amex_pkg::COND_AL, amex_pkg::ALU_TEQ, 1'b1, 4'd12, 4'd1,
			32'hFFFF_FFFF, 1'b1));
		offer_word(dp_word(amex_pkg::COND_AL, amex_pkg::ALU_EOR, 1'b1, 4'd10, 4'd2,
			32'hFFFF_FFFF, 1'b0));
		offer_word(dp_word(amex_pkg::COND_AL, amex_pkg::ALU_AND, 1'b1, 4'd11, 4'd1,
			32'hA5A5_A5A5, 1'b1));
		offer_word(dp_word(amex_pkg::COND_AL, amex_pkg::ALU_ORR, 1'b1, 4'd12, 4'd0,
			32'h0000_0000, 1'b0));
		offer_word(mul_word(amex_pkg::COND_AL, 1'b1, 4'd13, 4'd1, 4'd1, 1'b0, 4'd0));
		offer_word(mul_word(amex_pkg::COND_AL, 1'b1, 4'd14, 4'd2, 4'd3, 1'b1, 4'd1));
		offer_word(mul_word(amex_pkg::COND_AL, 1'b1, 4'd13, 4'd0, 4'd1, 1'b0, 4'd0));
		// nonzero product has to clear z again
		offer_word(mul_word(amex_pkg::COND_AL, 1'b1, 4'd13, 4'd3, 4'd3, 1'b0, 4'd0));
		offer_word(dp_word(amex_pkg::COND_AL, reserved_op(), 1'b1, 4'd6, 4'd1,
			32'hFFFF_FFFF, 1'b1));
		offer_word(dp_word(COND_NV, amex_pkg::ALU_MOV, 1'b1, 4'd6, 4'd0,
			32'h1234_5678, 1'b1));
		offer_word(dp_word(amex_pkg::COND_EQ, amex_pkg::ALU_MOV, 1'b1, 4'd6, 4'd0,
			32'h0000_0000, 1'b1));
		offer_word(dp_word(amex_pkg::COND_NE, amex_pkg::ALU_MOV, 1'b1, 4'd0, 4'd0,
			32'h8000_0000, 1'b0));
		offer_word(dp_word(amex_pkg::COND_AL, amex_pkg::ALU_ADD, 1'b1, 4'd15, 4'd15,
			32'h7FFF_FFFF, 1'b0));

		for (int i = 0; i < RandomWords; i++) begin
			if (i % 80 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			offer_word(random_word());
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (errors == 0 && pending == 0)
			$display("arm_alu_multiply_execute_tb: done, clean");
		else
			$display("arm_alu_multiply_execute_tb: done, errors");
		$finish;
	end

endmodule
